>>> hdl/sss_pkg.sv
// Shared types and constants for the sorted set store.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes on the mode field; the unused code behaves as a lookup.
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result flags handed from the scan sequencer to the output register.
  typedef struct packed {
    logic present;
    logic changed;
    logic full;
  } sss_result_t;

endpackage

`default_nettype wire

>>> hdl/sss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sss_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/sss_scan.sv
// Scan sequencer: walks the entry RAM once per item, compares and shifts.
`timescale 1ns / 1ps
`default_nettype none

module sss_scan #(
  parameter int CAPACITY   = sss_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sss_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = $clog2(CAPACITY + 1),
  parameter int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            start_mode,
  input  wire logic [VALUE_BITS-1:0] start_value,
  input  wire logic                  res_free,
  output logic                       idle,
  output logic                       done,
  output sss_pkg::sss_result_t       result,
  output logic [COUNT_BITS-1:0]      count,
  // entry RAM
  output logic                       wr_en,
  output logic [ADDR_BITS-1:0]       wr_addr,
  output logic [VALUE_BITS-1:0]      wr_data,
  output logic [ADDR_BITS-1:0]       rd_addr,
  input  wire logic [VALUE_BITS-1:0] rd_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

  logic [1:0]            state, state_next;
  logic [1:0]            mode;
  logic [VALUE_BITS-1:0] key;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] rd_idx, rd_idx_next;
  logic                  ex_valid, ex_valid_next;
  logic [ADDR_BITS-1:0]  ex_idx, ex_idx_next;
  logic                  shifting, shifting_next;
  logic [VALUE_BITS-1:0] carry, carry_next;
  sss_pkg::sss_result_t  result_next;

  logic is_ins, is_rem, may_write, lt, eq, stop;

  assign is_ins    = (mode == sss_pkg::MODE_INSERT);
  assign is_rem    = (mode == sss_pkg::MODE_REMOVE);
  assign may_write = (count < CAP_COUNT);
  assign lt        = ($signed(rd_data) < $signed(key));
  assign eq        = (rd_data == key);
  assign idle      = (state == ST_IDLE);
  assign rd_addr   = rd_idx[ADDR_BITS-1:0];

  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_idx_next   = rd_idx;
    ex_valid_next = 1'b0;
    ex_idx_next   = ex_idx;
    shifting_next = shifting;
    carry_next    = carry;
    result_next   = result;
    wr_en         = 1'b0;
    wr_addr       = ex_idx;
    wr_data       = carry;
    done          = 1'b0;
    stop          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next    = ST_SCAN;
          rd_idx_next   = '0;
          shifting_next = 1'b0;
          result_next   = '0;
        end
      end
      ST_SCAN: begin
        // examine the entry read last cycle
        if (ex_valid) begin
          if (shifting) begin
            wr_en = 1'b1;
            if (is_ins) begin
              wr_addr    = ex_idx;
              wr_data    = carry;
              carry_next = rd_data;
            end else begin
              wr_addr = ex_idx - ADDR_BITS'(1);
              wr_data = rd_data;
            end
          end else if (lt) begin
            stop = 1'b0;
          end else if (eq) begin
            result_next.present = 1'b1;
            if (is_rem) begin
              shifting_next = 1'b1;
            end else begin
              stop = 1'b1;
            end
          end else if (is_ins && may_write) begin
            wr_en         = 1'b1;
            wr_addr       = ex_idx;
            wr_data       = key;
            carry_next    = rd_data;
            shifting_next = 1'b1;
          end else begin
            stop             = 1'b1;
            result_next.full = is_ins;
          end
        end
        if (stop) begin
          state_next = ST_DONE;
        end else if (rd_idx < count) begin
          rd_idx_next   = rd_idx + COUNT_BITS'(1);
          ex_valid_next = 1'b1;
          ex_idx_next   = rd_idx[ADDR_BITS-1:0];
        end else if (!ex_valid) begin
          // every held entry seen
          if (is_ins) begin
            if (may_write) begin
              wr_en               = 1'b1;
              wr_addr             = count[ADDR_BITS-1:0];
              wr_data             = shifting ? carry : key;
              count_next          = count + COUNT_BITS'(1);
              result_next.changed = 1'b1;
            end else begin
              result_next.full = 1'b1;
            end
          end else if (is_rem && shifting) begin
            count_next          = count - COUNT_BITS'(1);
            result_next.changed = 1'b1;
          end
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ex_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ex_valid <= ex_valid_next;
    end
    if (idle && start) begin
      mode <= start_mode;
      key  <= start_value;
    end
    rd_idx   <= rd_idx_next;
    ex_idx   <= ex_idx_next;
    shifting <= shifting_next;
    carry    <= carry_next;
    result   <= result_next;
  end

endmodule

`default_nettype wire

>>> hdl/sorted_set_store.sv
// Top level of the sorted set store: handshakes, scan sequencer, entry RAM.
`timescale 1ns / 1ps
`default_nettype none

// Sorted set store. Holds up to CAPACITY distinct signed values in one
// RAM, kept in ascending order, plus a held-entry count. Each input beat
// carries a mode (lookup, insert, remove; the unused code acts as a lookup)
// and a value, and produces exactly one output beat with was_present,
// changed, store_full and the entry count after the operation. An insert
// of a value not held into a full store is refused with store_full set;
// inserting one already held, or removing one not held, changes nothing.
// Timing: one item at a time. The walk stops at the first entry not below
// the value for lookups, removes of absent values and refused or duplicate
// inserts, and covers the whole held set for inserts and removes that
// change the store. The walk is paced by the RAM's single read port, which
// feeds one entry per cycle to the shared compare and shift datapath.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register, so a new beat may be accepted while the previous result
// is still waiting. The sequencer only stalls at the end of an item if that
// register holds a result that is not being taken.
// No clearing pass is needed after reset: only entries below the count
// are ever used.
module sorted_set_store #(
  parameter int CAPACITY   = sss_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sss_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input beats
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            mode,
  input  wire logic [VALUE_BITS-1:0] value,
  // output beats
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       was_present,
  output logic                       changed,
  output logic                       store_full,
  output logic [COUNT_BITS-1:0]      entry_count
);

  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  scan_idle;
  logic                  scan_done;
  logic                  res_free;
  sss_pkg::sss_result_t  scan_result;
  logic [COUNT_BITS-1:0] scan_count;

  logic                  ram_wr_en;
  logic [ADDR_BITS-1:0]  ram_wr_addr;
  logic [VALUE_BITS-1:0] ram_wr_data;
  logic [ADDR_BITS-1:0]  ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_rd_data;

  assign in_ready = scan_idle;
  // output register can take a result this cycle
  assign res_free = !out_valid || out_ready;

  sss_scan #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (in_valid),
    .start_mode  (mode),
    .start_value (value),
    .res_free    (res_free),
    .idle        (scan_idle),
    .done        (scan_done),
    .result      (scan_result),
    .count       (scan_count),
    .wr_en       (ram_wr_en),
    .wr_addr     (ram_wr_addr),
    .wr_data     (ram_wr_data),
    .rd_addr     (ram_rd_addr),
    .rd_data     (ram_rd_data)
  );

  sss_ram #(
    .WIDTH     (VALUE_BITS),
    .DEPTH     (CAPACITY),
    .ADDR_BITS (ADDR_BITS)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register: loaded when the sequencer finishes, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (scan_done) begin
      was_present <= scan_result.present;
      changed     <= scan_result.changed;
      store_full  <= scan_result.full;
      entry_count <= scan_count;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_sorted_set_store.sv
// Self-checking testbench for the sorted set store: directed and random beats.
`timescale 1ns / 1ps

module tb_sorted_set_store;

  localparam int CAP       = sss_pkg::CAPACITY_DEF;
  localparam int VBITS     = sss_pkg::VALUE_BITS_DEF;
  localparam int COUNT_W   = $clog2(CAP + 1);
  localparam int POOL_SIZE = 72;
  // Unused mode code; the block must treat it as a lookup.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // One expected output beat.
  typedef struct packed {
    logic               was_present;
    logic               changed;
    logic               store_full;
    logic [COUNT_W-1:0] entry_count;
  } set_result_t;

  // Stimulus episodes: biased toward growing, churning or shrinking the set.
  typedef enum {EP_FILL, EP_MIXED, EP_DRAIN} episode_t;

  // Shadow copy of the set plus the queue of results still owed by the block.
  class set_scoreboard;
    logic signed [VBITS-1:0] shadow_entries [CAP];
    int                      shadow_held;
    set_result_t             pending_results [$];
    int                      errors;

    function new();
      shadow_held = 0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one operation to the shadow set and return the result it owes.
    function set_result_t shadow_apply(logic [1:0] m, logic signed [VBITS-1:0] v);
      set_result_t r;
      int          slot;
      int          k;
      logic        hit;
      slot = 0;
      while (slot < shadow_held && shadow_entries[slot] < v)
        slot++;
      hit = (slot < shadow_held) && (shadow_entries[slot] == v);
      r = '0;
      r.was_present = hit;
      if (m == sss_pkg::MODE_INSERT && !hit) begin
        if (shadow_held >= CAP) begin
          r.store_full = 1'b1;
        end else begin
          for (k = shadow_held; k > slot; k--)
            shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[slot] = v;
          shadow_held++;
          r.changed = 1'b1;
        end
      end else if (m == sss_pkg::MODE_REMOVE && hit) begin
        for (k = slot + 1; k < shadow_held; k++)
          shadow_entries[k - 1] = shadow_entries[k];
        shadow_held--;
        r.changed = 1'b1;
      end
      r.entry_count = COUNT_W'(shadow_held);
      return r;
    endfunction

    function void note_input(logic [1:0] m, logic signed [VBITS-1:0] v);
      pending_results.push_back(shadow_apply(m, v));
    endfunction

    task check_result(set_result_t got);
      set_result_t want;
      if (pending_results.size() == 0) begin
        report("output beat with no pending expectation");
      end else begin
        want = pending_results.pop_front();
        if (got.was_present !== want.was_present)
          report($sformatf("was_present got %b want %b", got.was_present, want.was_present));
        if (got.changed !== want.changed)
          report($sformatf("changed got %b want %b", got.changed, want.changed));
        if (got.store_full !== want.store_full)
          report($sformatf("store_full got %b want %b", got.store_full, want.store_full));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count got %0d want %0d", got.entry_count, want.entry_count));
      end
    endtask
  endclass

  // Everything the testbench drives starts at a known value.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [1:0]         mode      = sss_pkg::MODE_LOOKUP;
  logic [VBITS-1:0]   value     = '0;
  logic               out_ready = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire                was_present;
  wire                changed;
  wire                store_full;
  wire [COUNT_W-1:0]  entry_count;

  // Idle percentages for the sender and the receiver, changed per phase.
  int gap_pct   = 0;
  int stall_pct = 0;

  logic signed [VBITS-1:0] value_pool [POOL_SIZE];
  set_scoreboard           sb;

  sorted_set_store dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .was_present (was_present),
    .changed     (changed),
    .store_full  (store_full),
    .entry_count (entry_count)
  );

  always #4 clk = ~clk;

  // Receiver: ready is redrawn every falling edge, so stalls land on any cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Output beats are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{was_present, changed, store_full, entry_count});
  end

  // Send one input beat. Called at a falling edge and returns at one; in_valid
  // is driven low over any random gap, then held high until in_ready is seen.
  task send_beat(logic [1:0] m, logic [VBITS-1:0] v);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m, v);
    @(negedge clk);
  endtask

  // Fresh pool of values for a phase; duplicates among draws give repeat hits.
  // The extremes of the value range are always in it.
  task refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++)
      value_pool[i] = $urandom;
    value_pool[0] = {1'b1, {(VBITS-1){1'b0}}};
    value_pool[1] = {1'b0, {(VBITS-1){1'b1}}};
    value_pool[2] = '0;
    value_pool[3] = '1;
  endtask

  function logic [1:0] pick_mode(episode_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      EP_FILL: begin
        if (r < 70)      return sss_pkg::MODE_INSERT;
        else if (r < 80) return sss_pkg::MODE_LOOKUP;
        else if (r < 95) return sss_pkg::MODE_REMOVE;
        else             return MODE_SPARE;
      end
      EP_DRAIN: begin
        if (r < 65)      return sss_pkg::MODE_REMOVE;
        else if (r < 80) return sss_pkg::MODE_INSERT;
        else if (r < 95) return sss_pkg::MODE_LOOKUP;
        else             return MODE_SPARE;
      end
      default: begin
        if (r < 35)      return sss_pkg::MODE_INSERT;
        else if (r < 70) return sss_pkg::MODE_REMOVE;
        else if (r < 90) return sss_pkg::MODE_LOOKUP;
        else             return MODE_SPARE;
      end
    endcase
  endfunction

  // Values mostly come from what is held or from the phase pool, so that
  // lookups and removes hit, duplicates land on a full store, and the set
  // grows to capacity; the rest are free 32-bit draws.
  function logic [VBITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (sb.shadow_held > 0 && r < 35)
      return sb.shadow_entries[$urandom_range(0, sb.shadow_held - 1)];
    else if (r < 80)
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      return $urandom;
  endfunction

  task run_episode(episode_t kind, int beats);
    int i;
    for (i = 0; i < beats; i++)
      send_beat(pick_mode(kind), pick_value());
  endtask

  // One idling phase: grow to full, churn, then shrink toward empty.
  task run_phase(int gap, int stall);
    gap_pct   = gap;
    stall_pct = stall;
    refresh_pool();
    run_episode(EP_FILL, 150);
    run_episode(EP_MIXED, 90);
    run_episode(EP_DRAIN, 150);
  endtask

  // Hard limit on the whole run, far above the slowest legal schedule.
  initial begin
    #8_000_000;
    $display("[sorted_set_store] ERROR");
    $finish;
  end

  initial begin
    int drain_cycles;
    logic [VBITS-1:0] vmin;
    logic [VBITS-1:0] vmax;
    sb   = new();
    vmin = {1'b1, {(VBITS-1){1'b0}}};
    vmax = {1'b0, {(VBITS-1){1'b1}}};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, no idling: empty store, extremes, ordering at both ends
    // and the middle, duplicate insert, absent remove, spare mode.
    send_beat(sss_pkg::MODE_LOOKUP, '0);
    send_beat(sss_pkg::MODE_REMOVE, 32'd5);
    send_beat(sss_pkg::MODE_INSERT, '0);
    send_beat(sss_pkg::MODE_INSERT, vmin);
    send_beat(sss_pkg::MODE_INSERT, vmax);
    send_beat(sss_pkg::MODE_INSERT, '1);
    send_beat(sss_pkg::MODE_INSERT, 32'd1);
    send_beat(sss_pkg::MODE_INSERT, '0);
    send_beat(sss_pkg::MODE_LOOKUP, vmin);
    send_beat(sss_pkg::MODE_LOOKUP, vmax);
    send_beat(sss_pkg::MODE_LOOKUP, 32'd7);
    send_beat(MODE_SPARE, vmax);
    send_beat(MODE_SPARE, 32'd12345);
    send_beat(sss_pkg::MODE_REMOVE, vmax);
    send_beat(sss_pkg::MODE_REMOVE, vmin);
    send_beat(sss_pkg::MODE_REMOVE, '0);
    send_beat(sss_pkg::MODE_REMOVE, '0);
    send_beat(sss_pkg::MODE_LOOKUP, '0);
    send_beat(sss_pkg::MODE_INSERT, 32'h5555_5555);
    send_beat(sss_pkg::MODE_INSERT, 32'hAAAA_AAAA);
    send_beat(sss_pkg::MODE_REMOVE, '1);
    send_beat(sss_pkg::MODE_REMOVE, 32'd1);
    send_beat(sss_pkg::MODE_REMOVE, 32'h5555_5555);
    send_beat(sss_pkg::MODE_REMOVE, 32'hAAAA_AAAA);
    send_beat(sss_pkg::MODE_REMOVE, vmin);

    // Random part, one phase per idling pattern.
    run_phase(0, 0);
    run_phase(64, 0);
    run_phase(0, 64);
    run_phase(11, 11);

    in_valid <= 1'b0;

    // Wait for every owed result, then watch a while for stray beats.
    drain_cycles = 0;
    while (sb.pending_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
    repeat (4 * CAP) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[sorted_set_store] OK");
    end else begin
      $display("[sorted_set_store] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/sss_pkg.sv
hdl/sss_ram.sv
hdl/sss_scan.sv
hdl/sorted_set_store.sv
tb/tb_sorted_set_store.sv
